// File: sv/b64u_pkg.sv
// Shared types, constants and the symbol function for the base64url encoder.
// No dependencies. Imported by every module of the encoder.
package b64u_pkg;

    localparam int CMD_Q_DEPTH = 4;

    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_THREE   = 8'h33;
    localparam logic [7:0] CHR_D       = 8'h44;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // One classified input byte: one or two symbols, then zero to two "%3D" pads.
    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       two_syms;
        logic [1:0] pads;
        logic       last;
    } t_cmd;

    function automatic logic [7:0] sym_char(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            sym_char = 8'h41 + v;
        end else if (idx < 6'd52) begin
            sym_char = 8'h61 + v - 8'd26;
        end else if (idx < 6'd62) begin
            sym_char = 8'h30 + v - 8'd52;
        end else if (idx == 6'd62) begin
            sym_char = 8'h2d;
        end else begin
            sym_char = 8'h5f;
        end
    endfunction

endpackage

// File: sv/b64u_front.sv
// Front end: tracks the group phase and leftover bits and turns each byte into a command.
// Depends on b64u_pkg.
module b64u_front import b64u_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] w_b;
    logic       w_fin;

    assign w_b   = i_item.data_byte;
    assign w_fin = i_item.last_byte;

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        n_left  = r_left;
        unique case (r_phase)
            PHASE_SECOND: begin
                o_cmd.sym0 = {r_left[1:0], w_b[7:4]};
                if (w_fin) begin
                    o_cmd.sym1     = {w_b[3:0], 2'b00};
                    o_cmd.two_syms = 1'b1;
                    o_cmd.pads     = 2'd1;
                    o_cmd.last     = 1'b1;
                end
                n_phase = PHASE_THIRD;
                n_left  = w_b[3:0];
            end
            PHASE_THIRD: begin
                o_cmd.sym0     = {r_left, w_b[7:6]};
                o_cmd.sym1     = w_b[5:0];
                o_cmd.two_syms = 1'b1;
                o_cmd.last     = w_fin;
                n_phase        = PHASE_FIRST;
                n_left         = 4'd0;
            end
            default: begin
                o_cmd.sym0 = w_b[7:2];
                if (w_fin) begin
                    o_cmd.sym1     = {w_b[1:0], 4'b0000};
                    o_cmd.two_syms = 1'b1;
                    o_cmd.pads     = 2'd2;
                    o_cmd.last     = 1'b1;
                end
                n_phase = PHASE_SECOND;
                n_left  = {2'b00, w_b[1:0]};
            end
        endcase
        if (w_fin) begin
            n_phase = PHASE_FIRST;
            n_left  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_FIRST;
            r_left  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    a_phase_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3) else $error("Group phase reached an unused code.");
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_fin |=> r_phase == PHASE_FIRST && r_left == 4'd0)
        else $error("State was not cleared after the final byte.");
    a_left_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PHASE_THIRD |-> r_left[3:2] == 2'b00)
        else $error("Leftover bits too wide for the group phase.");

endmodule

// File: sv/b64u_cmdq.sv
// Small command queue between the front end and the character sequencer.
// Depends on b64u_pkg.
module b64u_cmdq import b64u_pkg::*; #(
    parameter int QDepth = CMD_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

    t_cmd            r_mem [QDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            w_wr, w_rd;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == LastPtr) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == LastPtr) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FullCnt) else $error("Queue count exceeds depth.");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == FullCnt) |-> r_wp == r_rp)
        else $error("Queue pointers disagree with count.");

endmodule

// File: sv/b64u_back.sv
// Character sequencer: expands one command into symbols and padding, one character a cycle unless the output stalls.
// Depends on b64u_pkg.
module b64u_back import b64u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_cmd,
    output logic      o_q_rd,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    logic [2:0] r_step;
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_last;
    logic [2:0] w_nsym, w_last_idx, w_p;
    logic [7:0] w_char;
    logic       w_load, w_end;

    assign w_nsym     = i_cmd.two_syms ? 3'd2 : 3'd1;
    assign w_last_idx = w_nsym - 3'd1 + {i_cmd.pads, 1'b0} + {1'b0, i_cmd.pads};
    assign w_p        = r_step - w_nsym;
    assign w_end      = (r_step == w_last_idx);
    assign w_load     = !i_q_empty && (!r_ov || i_pop);

    always_comb begin
        if (r_step == 3'd0) begin
            w_char = sym_char(i_cmd.sym0);
        end else if (r_step == 3'd1 && i_cmd.two_syms) begin
            w_char = sym_char(i_cmd.sym1);
        end else begin
            case (w_p) inside
                3'd0, 3'd3: w_char = CHR_PERCENT;
                3'd1, 3'd4: w_char = CHR_THREE;
                default:    w_char = CHR_D;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= i_cmd.last && w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_ov   <= 1'b0;
        end else begin
            r_ov <= w_load || (r_ov && !i_pop);
            if (w_load) begin
                r_step <= w_end ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    assign o_q_rd            = w_load && w_end;
    assign o_empty           = !r_ov;
    assign o_item.out_char   = r_char;
    assign o_item.last_char  = r_last;

    a_step_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 3'd0 |-> !i_q_empty) else $error("Sequencer mid-command with no command.");
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(r_step)) else $error("Step moved without a load.");
    a_pad_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_end && i_cmd.pads != 2'd0 |=> r_char == CHR_D)
        else $error("Padded command did not end in a pad character.");

endmodule

// File: sv/base64url_percent_pad_encoder_top.sv
// Top level of the streaming base64url encoder with percent-encoded padding.
// Depends on b64u_pkg, b64u_front, b64u_cmdq and b64u_back.
//
//  Channel   Handshake        Payload                 Accepted when
//  input     push / full      i_in_item (t_in_item)   push && !full
//  output    empty / pop      o_out_item (t_out_item) pop && !empty
//
// The front end takes one byte a cycle while the command queue has room.
// The sequencer emits one character a cycle while the output is popped: four
// per three bytes in a group, up to eight for a final byte, so the single
// output character register limits the sustained byte rate. A pushed byte goes
// through the command queue, then the output register. Reset is synchronous
// and clears phase, queue and output valid bit; a stalled pop holds the output.
module base64url_percent_pad_encoder_top import b64u_pkg::*; #(
    parameter int QDepth = CMD_Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_cmd w_cmd_in, w_cmd_out;
    logic w_accept, w_q_empty, w_q_rd;

    assign w_accept = push && !full;

    b64u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_cmd    (w_cmd_in)
    );

    b64u_cmdq #(.QDepth(QDepth)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_cmd   (w_cmd_out)
    );

    b64u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_cmd_out),
        .o_q_rd    (w_q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

endmodule
